// ===== design/acfb_pkg.sv =====
`default_nettype none

package acfb_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam int SEC0_LEN = 8;
    localparam int SEC1_LEN = 8;
    localparam int SEC2_LEN = 19;

    localparam logic [1:0] SEC_HDR0 = 2'd0;
    localparam logic [1:0] SEC_HDR1 = 2'd1;
    localparam logic [1:0] SEC_BODY = 2'd2;

    localparam logic [4:0] SEC0_LAST = 5'(SEC0_LEN - 1);
    localparam logic [4:0] SEC1_LAST = 5'(SEC1_LEN - 1);
    localparam logic [4:0] SEC2_LAST = 5'(SEC2_LEN - 1);

    localparam logic [2:0] MODE_AUTO = 3'd0;
    localparam logic [2:0] MODE_DRY  = 3'd1;
    localparam logic [2:0] MODE_COOL = 3'd2;
    localparam logic [2:0] MODE_HEAT = 3'd3;
    localparam logic [2:0] MODE_FAN  = 3'd4;

    localparam logic [2:0] FAN_S1    = 3'd0;
    localparam logic [2:0] FAN_S2    = 3'd1;
    localparam logic [2:0] FAN_S3    = 3'd2;
    localparam logic [2:0] FAN_S4    = 3'd3;
    localparam logic [2:0] FAN_S5    = 3'd4;
    localparam logic [2:0] FAN_AUTO  = 3'd5;
    localparam logic [2:0] FAN_NIGHT = 3'd6;

    localparam logic [7:0] HDR0 [SEC0_LEN] = '{
        8'h11, 8'hDA, 8'h27, 8'h00, 8'hC5, 8'h00, 8'h00, 8'hD7
    };
    localparam logic [7:0] HDR1 [SEC1_LEN] = '{
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h42, 8'h00, 8'h10, 8'h64
    };

    // Sum of the fixed bytes of the body section, with the eye byte at 0x80.
    localparam logic [7:0] BODY_SUM_BASE = 8'hB9;

    typedef struct packed {
        logic       err;
        logic       comfort;
        logic       eye;
        logic [7:0] mode_val;
        logic [7:0] temp_byte;
        logic [7:0] fan_val;
        logic       swing_h;
        logic       quiet;
        logic [7:0] csum;
    } t_cmd;

    function automatic logic [7:0] frame_byte_at(
        input logic [1:0] sec,
        input logic [4:0] pos,
        input t_cmd       cmd
    );
        logic [7:0] b;
        b = 8'h00;
        case (sec)
            SEC_HDR0: begin
                b = HDR0[pos[2:0]];
                if (cmd.comfort && pos[2:0] == 3'd6) begin
                    b = 8'h10;
                end
                if (cmd.comfort && pos[2:0] == 3'd7) begin
                    b = 8'hE7;
                end
            end
            SEC_HDR1: b = HDR1[pos[2:0]];
            SEC_BODY: begin
                case (pos)
                    5'd0:    b = 8'h11;
                    5'd1:    b = 8'hDA;
                    5'd2:    b = 8'h27;
                    5'd5:    b = cmd.mode_val;
                    5'd6:    b = cmd.temp_byte;
                    5'd8:    b = cmd.fan_val;
                    5'd9:    b = cmd.swing_h ? 8'h0F : 8'h00;
                    5'd11:   b = 8'h06;
                    5'd12:   b = 8'h60;
                    5'd13:   b = cmd.quiet ? 8'h20 : 8'h00;
                    5'd15:   b = 8'hC1;
                    5'd16:   b = cmd.eye ? 8'h82 : 8'h80;
                    5'd18:   b = cmd.csum;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/acfb_front.sv =====
`default_nettype none

module acfb_front
    import acfb_pkg::*;
(
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    output t_cmd                       o_cmd
);

    logic       power_on;
    logic [2:0] op_mode;
    logic       in_fahrenheit;
    logic [7:0] target_f;
    logic [7:0] target_c;
    logic [2:0] fan_setting;
    logic [1:0] sensor_setting;
    logic       swing_vert;
    logic       swing_horiz;
    logic       quiet_mode;

    logic        comfort;
    logic        eye;
    logic [11:0] c_times9;
    logic [19:0] c_scaled;
    logic [7:0]  mode_val;
    logic [7:0]  temp_byte;
    logic [7:0]  fan_val;
    logic [7:0]  csum;

    assign power_on       = i_tdata[0];
    assign op_mode        = i_tdata[3:1];
    assign in_fahrenheit  = i_tdata[4];
    assign target_f       = i_tdata[12:5];
    assign target_c       = i_tdata[20:13];
    assign fan_setting    = i_tdata[23:21];
    assign sensor_setting = i_tdata[25:24];
    assign swing_vert     = i_tdata[26];
    assign swing_horiz    = i_tdata[27];
    assign quiet_mode     = i_tdata[28];

    assign comfort = sensor_setting[1];
    assign eye     = sensor_setting[0];

    // Division by five through the reciprocal 205/1024, exact over the valid range.
    assign c_times9 = {4'd0, target_c} * 12'd9;
    assign c_scaled = {8'd0, c_times9} * 20'd205;

    always_comb begin
        case (op_mode)
            MODE_AUTO: mode_val = 8'h08;
            MODE_DRY:  mode_val = 8'h28;
            MODE_COOL: mode_val = 8'h38;
            MODE_HEAT: mode_val = 8'h48;
            MODE_FAN:  mode_val = 8'h68;
            default:   mode_val = 8'h38;
        endcase
        mode_val[0] = power_on;

        if (op_mode == MODE_DRY) begin
            temp_byte = 8'hC0;
        end else if (op_mode == MODE_FAN) begin
            temp_byte = 8'h32;
        end else if (in_fahrenheit) begin
            temp_byte = target_f - 8'd28;
        end else begin
            temp_byte = c_scaled[17:10] + 8'd4;
        end

        case (fan_setting)
            FAN_S1:    fan_val = 8'h30;
            FAN_S2:    fan_val = 8'h40;
            FAN_S3:    fan_val = 8'h50;
            FAN_S4:    fan_val = 8'h60;
            FAN_S5:    fan_val = 8'h70;
            FAN_AUTO:  fan_val = 8'hA0;
            FAN_NIGHT: fan_val = 8'hB0;
            default:   fan_val = 8'h50;
        endcase
        if (op_mode == MODE_DRY || comfort) begin
            fan_val = 8'hA0;
        end
        if (swing_vert) begin
            fan_val = fan_val | 8'h0F;
        end

        csum = BODY_SUM_BASE + {6'd0, eye, 1'b0} + mode_val + temp_byte + fan_val
             + (swing_horiz ? 8'h0F : 8'h00) + (quiet_mode ? 8'h20 : 8'h00);

        o_cmd.err       = in_fahrenheit ? (target_f < 8'd64 || target_f > 8'd90)
                                        : (target_c < 8'd18 || target_c > 8'd32);
        o_cmd.comfort   = comfort;
        o_cmd.eye       = eye;
        o_cmd.mode_val  = mode_val;
        o_cmd.temp_byte = temp_byte;
        o_cmd.fan_val   = fan_val;
        o_cmd.swing_h   = swing_horiz;
        o_cmd.quiet     = quiet_mode;
        o_cmd.csum      = csum;
    end

endmodule

`default_nettype wire

// ===== design/acfb_queue.sv =====
`default_nettype none

module acfb_queue
    import acfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end

endmodule

`default_nettype wire

// ===== design/acfb_back.sv =====
`default_nettype none

module acfb_back
    import acfb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire t_cmd                   i_cmd,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic                        o_tlast,
    output logic                        o_tuser
);

    logic [1:0] r_sec;
    logic [1:0] n_sec;
    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic       r_valid;
    logic       r_last;
    logic       r_err;
    logic [7:0] r_byte;
    logic [1:0] r_osec;
    logic [4:0] r_opos;

    logic load;
    logic is_last;

    assign load    = !i_empty && (!r_valid || i_tready);
    assign is_last = i_cmd.err || (r_sec == SEC_BODY && r_pos == SEC2_LAST);
    assign o_pop   = load && is_last;

    always_comb begin
        n_sec = r_sec;
        n_pos = r_pos + 5'd1;
        if (is_last) begin
            n_sec = SEC_HDR0;
            n_pos = 5'd0;
        end else if (r_sec == SEC_HDR0 && r_pos == SEC0_LAST) begin
            n_sec = SEC_HDR1;
            n_pos = 5'd0;
        end else if (r_sec == SEC_HDR1 && r_pos == SEC1_LAST) begin
            n_sec = SEC_BODY;
            n_pos = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec   <= SEC_HDR0;
            r_pos   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sec   <= n_sec;
                r_pos   <= n_pos;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= is_last;
            r_err  <= i_cmd.err;
            if (i_cmd.err) begin
                r_byte <= 8'h00;
                r_osec <= SEC_HDR0;
                r_opos <= 5'd0;
            end else begin
                r_byte <= frame_byte_at(r_sec, r_pos, i_cmd);
                r_osec <= r_sec;
                r_opos <= r_pos;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {1'b0, r_opos, r_osec, r_byte};
    assign o_tlast  = r_last;
    assign o_tuser  = r_err;

endmodule

`default_nettype wire

// ===== design/ac_ir_frame_builder.sv =====
// Channel  Dir  tdata fields (lowest bit up)                           tlast      tuser
// s_axis   in   power_on, op_mode, in_fahrenheit, target_f, target_c,  -          -
//               fan_setting, sensor_setting, swing_vert, swing_horiz,
//               quiet_mode (29 bits, zero-filled to 32)
// m_axis   out  frame_byte, section_no, byte_pos (15 bits, to 16)     last_byte  range_error
//
// A valid command yields 35 beats, one per cycle while the sink is ready; a
// range error yields a single beat. The output sequencer sets the rate; the
// next command's bytes follow the last byte with no gap. A two-entry queue,
// holding the command being sent too, buffers classified commands; the input
// takes commands until it is full, also during stalls. Reset is synchronous and active low.
`default_nettype none

module ac_ir_frame_builder
    import acfb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // see table above
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // frame_byte, section_no, byte_pos
    output logic                        m_axis_tlast,   // last_byte
    output logic                        m_axis_tuser    // range_error
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    acfb_front u_front (
        .i_tdata (s_axis_tdata),
        .o_cmd   (front_cmd)
    );

    acfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    acfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (head_cmd),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = !q_full;

endmodule

`default_nettype wire

// ===== tb/ac_ir_frame_builder_test.sv =====
`default_nettype none

module ac_ir_frame_builder_test;
    import acfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam logic [2:0] FAN_RSVD  = 3'd7;

    localparam logic [1:0] SENS_OFF     = 2'd0;
    localparam logic [1:0] SENS_EYE     = 2'd1;
    localparam logic [1:0] SENS_COMFORT = 2'd2;
    localparam logic [1:0] SENS_BOTH    = 2'd3;

    localparam int TF_MIN = 64;
    localparam int TF_MAX = 90;
    localparam int TC_MIN = 18;
    localparam int TC_MAX = 32;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;
    localparam int N_RANDOM   = 140;

    localparam logic [7:0] HEADER0 [8] = '{
        8'h11, 8'hDA, 8'h27, 8'h00, 8'hC5, 8'h00, 8'h00, 8'hD7
    };
    localparam logic [7:0] HEADER1 [8] = '{
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h42, 8'h00, 8'h10, 8'h64
    };
    localparam logic [7:0] MODE_CODE [5] = '{8'h08, 8'h28, 8'h38, 8'h48, 8'h68};
    localparam logic [7:0] FAN_CODE [7] = '{
        8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'hA0, 8'hB0
    };

    typedef struct packed {
        logic       power;
        logic [2:0] mode;
        logic       use_f;
        logic [7:0] target_f;
        logic [7:0] target_c;
        logic [2:0] fan;
        logic [1:0] sensor;
        logic       swing_v;
        logic       swing_h;
        logic       quiet;
    } t_ac_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] sec;
        logic [4:0] pos;
        logic       last;
        logic       err;
    } t_frame_beat;

    typedef struct packed {
        t_ac_cmd cmd;
        logic    range_err;
    } t_cmd_row;

    localparam t_frame_beat RANGE_ERR_BEAT = '{8'h00, SEC_HDR0, 5'd0, 1'b1, 1'b1};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // power_on, op_mode, in_fahrenheit, target_f,
                                            // target_c, fan_setting, sensor_setting,
                                            // swing_vert, swing_horiz, quiet_mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // frame_byte, section_no, byte_pos
    logic                   m_axis_tlast;   // last_byte
    logic                   m_axis_tuser;   // range_error

    t_frame_beat pending_beats [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          calm = 1'b0;

    t_cmd_row directed_rows [21] = '{
        '{'{1'b0, MODE_AUTO, 1'b0, 8'd0, 8'd18, FAN_S1, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b0},
        '{'{1'b1, MODE_COOL, 1'b0, 8'd255, 8'd32, FAN_S5, SENS_OFF, 1'b1, 1'b1, 1'b1}, 1'b0},
        '{'{1'b1, MODE_HEAT, 1'b0, 8'd64, 8'd17, FAN_AUTO, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b1, MODE_HEAT, 1'b0, 8'd64, 8'd33, FAN_AUTO, SENS_EYE, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b0, MODE_COOL, 1'b0, 8'd70, 8'd0, FAN_S2, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b0, MODE_COOL, 1'b0, 8'd70, 8'd255, FAN_S2, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b1, MODE_AUTO, 1'b1, 8'd64, 8'd0, FAN_NIGHT, SENS_EYE, 1'b0, 1'b0, 1'b0}, 1'b0},
        '{'{1'b1, MODE_HEAT, 1'b1, 8'd90, 8'd255, FAN_S4, SENS_BOTH, 1'b0, 1'b1, 1'b0}, 1'b0},
        '{'{1'b1, MODE_DRY, 1'b1, 8'd63, 8'd25, FAN_S3, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b0, MODE_FAN, 1'b1, 8'd91, 8'd25, FAN_S3, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b1, MODE_COOL, 1'b1, 8'd0, 8'd25, FAN_S1, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b1, MODE_COOL, 1'b1, 8'd255, 8'd25, FAN_S1, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b1},
        '{'{1'b1, MODE_DRY, 1'b0, 8'd0, 8'd25, FAN_S3, SENS_OFF, 1'b0, 1'b0, 1'b0}, 1'b0},
        '{'{1'b0, MODE_FAN, 1'b1, 8'd75, 8'd0, FAN_S2, SENS_COMFORT, 1'b0, 1'b0, 1'b1}, 1'b0},
        '{'{1'b1, MODE_RSVD5, 1'b0, 8'd128, 8'd20, FAN_RSVD, SENS_EYE, 1'b0, 1'b0, 1'b0}, 1'b0},
        '{'{1'b0, MODE_RSVD6, 1'b1, 8'd80, 8'd170, FAN_RSVD, SENS_COMFORT, 1'b0, 1'b1, 1'b0},
          1'b0},
        '{'{1'b1, MODE_RSVD7, 1'b0, 8'd85, 8'd31, FAN_S1, SENS_BOTH, 1'b1, 1'b0, 1'b1}, 1'b0},
        '{'{1'b1, MODE_DRY, 1'b1, 8'd66, 8'd0, FAN_RSVD, SENS_OFF, 1'b1, 1'b0, 1'b0}, 1'b0},
        '{'{1'b0, MODE_COOL, 1'b1, 8'd72, 8'd85, FAN_S3, SENS_OFF, 1'b0, 1'b1, 1'b1}, 1'b0},
        '{'{1'b1, MODE_DRY, 1'b0, 8'd70, 8'd0, FAN_RSVD, SENS_BOTH, 1'b1, 1'b1, 1'b1}, 1'b1},
        '{'{1'b1, MODE_RSVD7, 1'b1, 8'd255, 8'd255, FAN_RSVD, SENS_BOTH, 1'b1, 1'b1, 1'b1},
          1'b1}
    };

    ac_ir_frame_builder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [IN_TDATA_W-1:0] pack_cmd(input t_ac_cmd c);
        return {3'b000, c.quiet, c.swing_h, c.swing_v, c.sensor, c.fan,
                c.target_c, c.target_f, c.use_f, c.mode, c.power};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic predict_frame(input t_ac_cmd c);
        logic [7:0] hdr [8];
        logic [7:0] body [19];
        logic [7:0] mode_b;
        logic [7:0] temp_b;
        logic [7:0] fan_b;
        logic [7:0] sum;
        logic       comfort;
        logic       eye;
        t_frame_beat b;
        if (c.use_f ? (c.target_f < TF_MIN || c.target_f > TF_MAX)
                    : (c.target_c < TC_MIN || c.target_c > TC_MAX)) begin
            pending_beats.push_back(RANGE_ERR_BEAT);
            return;
        end
        comfort = (c.sensor == SENS_COMFORT || c.sensor == SENS_BOTH);
        eye = (c.sensor == SENS_EYE || c.sensor == SENS_BOTH);

        hdr = HEADER0;
        if (comfort) begin
            hdr[6] = 8'h10;
            sum = 8'h00;
            for (int i = 0; i < 7; i++) sum = sum + hdr[i];
            hdr[7] = sum;
        end

        mode_b = (c.mode < 5) ? MODE_CODE[c.mode] : 8'h38;
        mode_b[0] = mode_b[0] | c.power;

        case (c.mode)
            MODE_DRY: temp_b = 8'hC0;
            MODE_FAN: temp_b = 8'h32;
            default:  temp_b = c.use_f ? 8'(c.target_f - 8'd28)
                                       : 8'(int'(c.target_c) * 9 / 5 + 4);
        endcase

        if (c.mode == MODE_DRY) begin
            fan_b = 8'hA0;
        end else begin
            fan_b = (c.fan < 7) ? FAN_CODE[c.fan] : 8'h50;
        end
        if (comfort) fan_b = 8'hA0;
        if (c.swing_v) fan_b = fan_b | 8'h0F;

        foreach (body[i]) body[i] = 8'h00;
        body[0]  = 8'h11;
        body[1]  = 8'hDA;
        body[2]  = 8'h27;
        body[5]  = mode_b;
        body[6]  = temp_b;
        body[8]  = fan_b;
        body[9]  = c.swing_h ? 8'h0F : 8'h00;
        body[11] = 8'h06;
        body[12] = 8'h60;
        body[13] = c.quiet ? 8'h20 : 8'h00;
        body[15] = 8'hC1;
        body[16] = eye ? 8'h82 : 8'h80;
        sum = 8'h00;
        for (int i = 0; i < 18; i++) sum = sum + body[i];
        body[18] = sum;

        for (int i = 0; i < 8; i++) begin
            b = '{hdr[i], SEC_HDR0, 5'(i), 1'b0, 1'b0};
            pending_beats.push_back(b);
        end
        for (int i = 0; i < 8; i++) begin
            b = '{HEADER1[i], SEC_HDR1, 5'(i), 1'b0, 1'b0};
            pending_beats.push_back(b);
        end
        for (int i = 0; i < 19; i++) begin
            b = '{body[i], SEC_BODY, 5'(i), (i == 18), 1'b0};
            pending_beats.push_back(b);
        end
    endtask

    function automatic t_ac_cmd random_cmd();
        t_ac_cmd c;
        c.power    = 1'($urandom_range(0, 1));
        c.mode     = 3'($urandom_range(0, 7));
        c.use_f    = 1'($urandom_range(0, 1));
        c.fan      = 3'($urandom_range(0, 7));
        c.sensor   = 2'($urandom_range(0, 3));
        c.swing_v  = 1'($urandom_range(0, 1));
        c.swing_h  = 1'($urandom_range(0, 1));
        c.quiet    = 1'($urandom_range(0, 1));
        c.target_f = 8'($urandom_range(0, 255));
        c.target_c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) begin
            if (c.use_f) begin
                c.target_f = 8'($urandom_range(TF_MIN, TF_MAX));
            end else begin
                c.target_c = 8'($urandom_range(TC_MIN, TC_MAX));
            end
        end else if (c.use_f) begin
            c.target_f = 8'($urandom_range(0, 1) ? $urandom_range(0, TF_MIN - 1)
                                                 : $urandom_range(TF_MAX + 1, 255));
        end else begin
            c.target_c = 8'($urandom_range(0, 1) ? $urandom_range(0, TC_MIN - 1)
                                                 : $urandom_range(TC_MAX + 1, 255));
        end
        return c;
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_cmd(input t_ac_cmd c, input logic typed_err);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_cmd(c);
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed_err) begin
            pending_beats.push_back(RANGE_ERR_BEAT);
        end else begin
            predict_frame(c);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic void check_field(input string what, input logic [7:0] expv,
                                        input logic [7:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, expv, actv);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got tdata %0h last %b err %b",
                         $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end else begin
                e = pending_beats.pop_front();
                check_field("frame_byte", e.data, m_axis_tdata[7:0]);
                check_field("section_no", 8'(e.sec), 8'(m_axis_tdata[9:8]));
                check_field("byte_pos", 8'(e.pos), 8'(m_axis_tdata[14:10]));
                check_field("last_byte", 8'(e.last), 8'(m_axis_tlast));
                check_field("range_error", 8'(e.err), 8'(m_axis_tuser));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].range_err);
        end
        drain_frames();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 30) hold_req = 1'b1;
            if (n == 90) calm = 1'b1;
            if (n == 115) calm = 1'b0;
            if (n == 125) drain_frames();
            send_cmd(random_cmd(), 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
